FILE: hdl/skis_pkg.sv
// Shared types, constants and the sequencer microcode for the sorted key search block.
package skis_pkg;

   // table geometry and field widths
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int ENTRY_W     = 10;
   localparam int POS_W       = 11;
   localparam int CMD_W       = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int RSP_DATA_W  = ((POS_W + 7) / 8) * 8;

   // command codes carried on req_tuser
   localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH_ALL = 2'd2;

   // register index of key_count on the csr port (paddr[2])
   localparam logic REG_KEY_COUNT = 1'b0;

   // microprogram steps
   localparam int STEP_W = 2;
   localparam logic [STEP_W-1:0] STEP_FETCH = 2'd0;
   localparam logic [STEP_W-1:0] STEP_SETUP = 2'd1;
   localparam logic [STEP_W-1:0] STEP_PROBE = 2'd2;
   localparam logic [STEP_W-1:0] STEP_EMIT  = 2'd3;

   // branch conditions
   typedef enum logic [1:0] {
      COND_NEVER,
      COND_SEARCH,
      COND_SEG_OPEN,
      COND_OUT_BUSY
   } skis_cond_type;

   // control lines driven into the datapath
   typedef struct packed {
      logic take_req;
      logic load_seg;
      logic probe;
      logic emit;
   } skis_ctrl_type;

   // status lines fed back to the sequencer
   typedef struct packed {
      logic search_acc;
      logic seg_open;
      logic out_busy;
   } skis_flags_type;

   // one control word
   typedef struct packed {
      skis_ctrl_type            ctrl;
      skis_cond_type            cond;
      logic [STEP_W-1:0]        jump_to;
      logic [STEP_W-1:0]        next_to;
   } skis_uword_type;

   // control store: branch to jump_to when cond holds, else go to next_to
   function automatic skis_uword_type microcode(input logic [STEP_W-1:0] step);
      skis_uword_type w;
      w = '{ctrl: '0, cond: COND_NEVER, jump_to: STEP_FETCH, next_to: STEP_FETCH};
      case (step)
         STEP_FETCH: begin
            w.ctrl.take_req = 1'b1;
            w.cond          = COND_SEARCH;
            w.jump_to       = STEP_SETUP;
            w.next_to       = STEP_FETCH;
         end
         STEP_SETUP: begin
            w.ctrl.load_seg = 1'b1;
            w.cond          = COND_NEVER;
            w.next_to       = STEP_PROBE;
         end
         STEP_PROBE: begin
            w.ctrl.probe = 1'b1;
            w.cond       = COND_SEG_OPEN;
            w.jump_to    = STEP_PROBE;
            w.next_to    = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.ctrl.emit = 1'b1;
            w.cond      = COND_OUT_BUSY;
            w.jump_to   = STEP_EMIT;
            w.next_to   = STEP_FETCH;
         end
         default: begin
            w.next_to = STEP_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: hdl/skis_seq.sv
// Microcoded sequencer: step counter, control store lookup and branch evaluation.
module skis_seq
   import skis_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  skis_flags_type flags,
   output skis_ctrl_type  ctrl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   skis_uword_type    uword;
   logic              taken;

   // fetch current control word
   assign uword = microcode(step_ff);
   assign ctrl  = uword.ctrl;

   // branch condition
   always_comb begin
      case (uword.cond)
         COND_NEVER:    taken = 1'b0;
         COND_SEARCH:   taken = flags.search_acc;
         COND_SEG_OPEN: taken = flags.seg_open;
         COND_OUT_BUSY: taken = flags.out_busy;
         default:       taken = 1'b0;
      endcase
      step_in = taken ? uword.jump_to : uword.next_to;
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

FILE: hdl/sorted_key_insertion_search.sv
// Top level: sorted key table with upper-bound binary search, driven by a microsequencer.
//
// Usage:
//  - req_* stream carries one command per transfer: req_tuser selects write key,
//    search segment or search whole table. A write stores a key and gives no result.
//  - rsp_* stream returns one transfer per search: the upper-bound insertion
//    position in tdata, the end-clamped flag in tuser.
//  - csr_* APB port holds key_count at byte address 0; write it only while idle.
// Sequencing:
//  - A write leaves the sequencer on fetch; the next command is taken in the following cycle.
//  - A search is taken on fetch, loads its segment on setup, then probes until the
//    interval is empty, each probe comparing against the registered read of the
//    table's read port and issuing a new read address; the result is then loaded
//    into the output register on the emit step.
//  - The next command is accepted in the cycle after the result is loaded, even
//    while that result still waits on rsp_tready.
// Reset: the sequencer returns to fetch, key_count clears to 0, rsp_tvalid drops.
//  Table contents are not cleared; entries must be written before being searched.
// Stall: if rsp_tready stays low the sequencer holds on its emit step and
//  req_tready stays low until the output register frees up.
module sorted_key_insertion_search
   import skis_pkg::*;
#(
   parameter int KEY_WIDTH = 32
)(
   input  logic                  clock,
   input  logic                  reset,
   // entry_index, key_value, seg_start, seg_end (lowest bits first)
   input  logic [((ENTRY_W + KEY_WIDTH + 2 * POS_W + 7) / 8) * 8 - 1:0] req_tdata,
   // cmd
   input  logic [CMD_W-1:0]      req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // insert_position
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // end_clamped
   output logic                  rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // field offsets in req_tdata
   localparam int KEY_LSB   = ENTRY_W;
   localparam int START_LSB = KEY_LSB + KEY_WIDTH;
   localparam int END_LSB   = START_LSB + POS_W;

   skis_ctrl_type  ctrl;
   skis_flags_type flags;

   logic                 req_xfer;
   logic                 key_count_wr;
   logic [POS_W-1:0]     key_count_ff;
   logic [POS_W-1:0]     limit;

   logic [ENTRY_W-1:0]   req_entry;
   logic [KEY_WIDTH-1:0] req_key;
   logic [POS_W-1:0]     req_start;
   logic [POS_W-1:0]     req_end;

   logic [KEY_WIDTH-1:0] target_ff;
   logic [POS_W-1:0]     start_ff;
   logic [POS_W-1:0]     end_ff;
   logic                 whole_ff;

   logic [POS_W-1:0]     lo_ff, lo_in;
   logic [POS_W-1:0]     hi_ff, hi_in;
   logic                 clamp_ff, clamp_in;
   logic [POS_W:0]       mid_sum;
   logic [POS_W-1:0]     mid_in;
   logic [POS_W-1:0]     mid_ff;
   logic                 key_above;

   logic [KEY_WIDTH-1:0] key_mem [TABLE_DEPTH];
   logic [KEY_WIDTH-1:0] rd_data_ff;

   logic                 rsp_load;
   logic                 rsp_valid_ff;
   logic [POS_W-1:0]     rsp_pos_ff;
   logic                 rsp_clamp_ff;

   // sequencer
   skis_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   // input fields
   assign req_entry = req_tdata[ENTRY_W-1:0];
   assign req_key   = req_tdata[START_LSB-1:KEY_LSB];
   assign req_start = req_tdata[END_LSB-1:START_LSB];
   assign req_end   = req_tdata[END_LSB+POS_W-1:END_LSB];

   // no transfer is taken while reset is held
   assign req_tready = ctrl.take_req && !reset;
   assign req_xfer   = req_tvalid && req_tready;

   // status back to the sequencer
   assign flags.search_acc = req_xfer &&
                             (req_tuser == CMD_SEARCH || req_tuser == CMD_SEARCH_ALL);
   assign flags.seg_open   = lo_ff < hi_ff;
   assign flags.out_busy   = rsp_valid_ff && !rsp_tready;

   // config register
   assign csr_pready   = 1'b1;
   assign key_count_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                         (csr_paddr[2] == REG_KEY_COUNT);
   assign csr_prdata   = (csr_paddr[2] == REG_KEY_COUNT) ? CSR_DATA_W'(key_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
      end else if (key_count_wr) begin
         key_count_ff <= csr_pwdata[POS_W-1:0];
      end
   end

   // key count saturated to the table size
   assign limit = (key_count_ff > POS_W'(TABLE_DEPTH)) ? POS_W'(TABLE_DEPTH) : key_count_ff;

   // command fields captured on transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         target_ff <= req_key;
         start_ff  <= req_start;
         end_ff    <= req_end;
         whole_ff  <= (req_tuser == CMD_SEARCH_ALL);
      end
   end

   // interval update: segment setup or one halving probe
   assign key_above = $signed(target_ff) < $signed(rd_data_ff);

   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      clamp_in = clamp_ff;
      if (ctrl.load_seg) begin
         if (whole_ff) begin
            lo_in    = '0;
            hi_in    = limit;
            clamp_in = 1'b0;
         end else begin
            lo_in    = start_ff;
            hi_in    = (end_ff > limit) ? limit : end_ff;
            clamp_in = (end_ff > limit);
         end
      end else if (ctrl.probe && flags.seg_open) begin
         if (key_above) begin
            hi_in = mid_ff;
         end else begin
            lo_in = mid_ff + POS_W'(1);
         end
      end
   end

   // midpoint of the next interval, read in the same cycle
   assign mid_sum = {1'b0, lo_in} + {1'b0, hi_in};
   assign mid_in  = mid_sum[POS_W:1];

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      clamp_ff <= clamp_in;
      mid_ff   <= mid_in;
   end

   // key table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (req_xfer && req_tuser == CMD_WRITE) begin
         key_mem[req_entry[ADDR_W-1:0]] <= req_key;
      end
      rd_data_ff <= key_mem[mid_in[ADDR_W-1:0]];
   end

   // output register
   assign rsp_load = ctrl.emit && !flags.out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pos_ff   <= lo_ff;
         rsp_clamp_ff <= clamp_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_pos_ff);
   assign rsp_tuser  = rsp_clamp_ff;

`ifndef NO_ASSERTIONS
   // a probe never inverts the interval
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.probe && flags.seg_open) |=> (lo_ff <= hi_ff))
      else $error("search interval inverted after probe");

   // every probe of an open interval strictly shrinks the interval
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.probe && flags.seg_open) |=> ((hi_ff - lo_ff) < $past(hi_ff - lo_ff)))
      else $error("search interval did not shrink");

   // loading a result returns the sequencer to fetch
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> ctrl.take_req)
      else $error("sequencer not back at fetch after result");

   // a whole-table search never reports a clamp
   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && whole_ff) |=> !rsp_tuser)
      else $error("clamp flag set on whole-table search");
`endif

endmodule
